### src/ssicrc_pkg.sv
// Shared types, constants and the CRC-6 function for the SSI encoder frame checker.
package ssicrc_pkg;

  localparam int RX_BYTE_W   = 8;
  localparam int ANGLE_W     = 14;
  localparam int CRC_W       = 6;
  localparam int CRC_DATA_W  = 18;
  localparam int PARTIAL_W   = 16;

  // One input transaction.
  typedef struct packed {
    logic [RX_BYTE_W-1:0] rx_byte;
    logic                 first_of_frame;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               angle_valid;
    logic               frame_done;
    logic               crc_match;
  } out_item_t;

  // Position of the next byte within a frame.
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } byte_pos_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    byte_pos_t            byte_pos;
    logic [PARTIAL_W-1:0] partial;
    logic [ANGLE_W-1:0]   held_angle;
    logic                 seen_good;
  } dec_state_t;

  // Contribution of each data bit k to the remainder: x^(k+6) mod (x^6 + x + 1).
  localparam logic [CRC_W-1:0] CRC_COLUMN [CRC_DATA_W] = '{
    6'h03, 6'h06, 6'h0C, 6'h18, 6'h30, 6'h23,
    6'h05, 6'h0A, 6'h14, 6'h28, 6'h13, 6'h26,
    6'h0F, 6'h1E, 6'h3C, 6'h3B, 6'h35, 6'h29
  };

  // CRC-6, zero initial value, MSB first, as an XOR of independent columns.
  function automatic logic [CRC_W-1:0] crc6_of(input logic [CRC_DATA_W-1:0] data);
    logic [CRC_W-1:0] crc;
    crc = '0;
    for (int k = 0; k < CRC_DATA_W; k++) begin
      if (data[k]) begin
        crc = crc ^ CRC_COLUMN[k];
      end
    end
    return crc;
  endfunction

endpackage

### src/ssi_encoder_frame_crc_check.sv
// Top level of the CRC-6 checked SSI absolute-encoder frame decoder.
//
// Usage: frame bytes arrive on the input channel (in_valid, in_stall,
// in_data), most significant byte first, three to a frame. Setting
// first_of_frame on a byte restarts the frame at that byte; without it the
// block simply counts bytes and frames run on back to back.
// Every input transaction produces exactly one result transaction on the
// output channel (out_valid, out_stall, out_data) carrying the held angle,
// the sticky angle_valid flag and the frame_done and crc_match flags.
// The byte is held in the input register, then the CRC check and state
// update run in a single pass into the result register. The block takes
// one byte per cycle while the receiver does not stall, set by that single
// register-to-register pass.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more byte; in_stall rises only when
// both registers are full.
// A synchronous active-low reset empties both registers, returns the byte
// position to the first byte and clears the held angle and valid flag.
module ssi_encoder_frame_crc_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ssicrc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ssicrc_pkg::out_item_t out_data
);
  import ssicrc_pkg::*;

  // Input register stage.
  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_item_r;

  // Decoder state and result register.
  dec_state_t state_r, state_nxt;
  out_item_t  out_data_r, result;
  logic       out_valid_r, out_valid_nxt;

  logic       in_accept;
  logic       out_free;
  logic       s1_fire;

  // The result register can take a new transaction when it is empty or is
  // being drained in this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  ssicrc_frame_dec u_dec (
    .item      (s1_item_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      state_r.byte_pos    <= POS_FIRST;
      state_r.partial     <= '0;
      state_r.held_angle  <= '0;
      state_r.seen_good   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A CRC match is only reported on a completed frame, and it sets the valid flag.
  a_match_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.crc_match |-> out_data_r.frame_done && out_data_r.angle_valid)
    else $error("crc_match reported without frame_done or angle_valid");

  // The unused byte position code is never reached.
  a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_pos == POS_FIRST || state_r.byte_pos == POS_SECOND ||
    state_r.byte_pos == POS_THIRD)
    else $error("byte position left its legal range");

  // The valid flag is sticky until reset.
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(state_r.seen_good) |-> state_r.seen_good)
    else $error("angle valid flag dropped without reset");

  // Back-pressure only when the input register holds a transaction.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled while the pipeline had room");

endmodule

### src/ssicrc_frame_dec.sv
// Byte-position tracking, frame assembly and CRC check for one received byte.
module ssicrc_frame_dec (
  input  ssicrc_pkg::in_item_t   item,
  input  ssicrc_pkg::dec_state_t state_cur,
  output ssicrc_pkg::dec_state_t state_nxt,
  output ssicrc_pkg::out_item_t  result
);
  import ssicrc_pkg::*;

  byte_pos_t             pos;
  logic [23:0]           frame;
  logic                  match;
  logic                  done;

  assign frame = {state_cur.partial, item.rx_byte};
  assign match = (frame[CRC_W-1:0] == crc6_of(frame[23:CRC_W]));

  always_comb begin
    pos       = item.first_of_frame ? POS_FIRST : state_cur.byte_pos;
    state_nxt = state_cur;
    done      = 1'b0;
    case (pos)
      POS_SECOND: begin
        state_nxt.partial  = {state_cur.partial[PARTIAL_W-1:RX_BYTE_W], item.rx_byte};
        state_nxt.byte_pos = POS_THIRD;
      end
      POS_THIRD: begin
        done               = 1'b1;
        state_nxt.byte_pos = POS_FIRST;
        if (match) begin
          state_nxt.held_angle = frame[23:10];
          state_nxt.seen_good  = 1'b1;
        end
      end
      default: begin
        // First byte, and also the unused position code.
        state_nxt.partial  = {item.rx_byte, {RX_BYTE_W{1'b0}}};
        state_nxt.byte_pos = POS_SECOND;
      end
    endcase
    result.angle       = state_nxt.held_angle;
    result.angle_valid = state_nxt.seen_good;
    result.frame_done  = done;
    result.crc_match   = done & match;
  end

endmodule
